>>> rtl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// shared types, character codes and the fixed overflow message for the
// console line editor
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int LINE_LENGTH_DEF = 32;
    localparam int MSG_LEN         = 19;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic DEST_TERM = 1'b0;
    localparam logic DEST_CMD  = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        M_ECHO,
        M_BS,
        M_ENTER
    } t_mode;

    // "Command too long." CR LF
    function automatic logic [7:0] msg_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = 8'h43;
            5'd1:    c = 8'h6F;
            5'd2:    c = 8'h6D;
            5'd3:    c = 8'h6D;
            5'd4:    c = 8'h61;
            5'd5:    c = 8'h6E;
            5'd6:    c = 8'h64;
            5'd7:    c = 8'h20;
            5'd8:    c = 8'h74;
            5'd9:    c = 8'h6F;
            5'd10:   c = 8'h6F;
            5'd11:   c = 8'h20;
            5'd12:   c = 8'h6C;
            5'd13:   c = 8'h6F;
            5'd14:   c = 8'h6E;
            5'd15:   c = 8'h67;
            5'd16:   c = 8'h2E;
            5'd17:   c = CH_CR;
            5'd18:   c = CH_LF;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/console_line_editor_core.sv
// ----------------------------------------------------------------------------
// console_line_editor_core
// serial console line editor with echo and command line hand-off
// ----------------------------------------------------------------------------
// Takes one received terminal byte per input word and edits a line of up to
// LINE_LENGTH-1 characters. Each output word carries one character with its
// destination (terminal echo or command line) and a flag on the last word
// caused by the input byte. An input byte is taken while the block is idle; if
// it yields words, the block then stalls its input while a small sequencer pushes
// the resulting words through the single output register, one per cycle when the
// output is not stalled: 1 word for a stored byte echo, 3 for a backspace, 2 plus
// the line length (or 21 for an overlong line) for Enter. Line characters are
// read back from the line store through its registered read port, one address
// per cycle when the output is not stalled.
// ----------------------------------------------------------------------------
module console_line_editor_core #(
    parameter int LINE_LENGTH = cle_pkg::LINE_LENGTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_dest,
    output logic       o_run_last
);
    import cle_pkg::*;

    localparam int DEPTH   = LINE_LENGTH - 1;
    localparam int CW      = $clog2(LINE_LENGTH);
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAX_RES = (LINE_LENGTH + 1 > MSG_LEN + 2) ? LINE_LENGTH + 1 : MSG_LEN + 2;
    localparam int PW      = $clog2(MAX_RES + 1);

    logic [7:0] mem [DEPTH];

    t_state       r_state, n_state;
    t_mode        r_mode, n_mode;
    logic [CW-1:0] r_count, n_count;
    logic         r_ovf, n_ovf;
    logic         r_prev_cr, n_prev_cr;
    logic         r_msg_mode, n_msg_mode;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_total, n_total;
    logic [7:0]   r_echo, n_echo;
    logic [7:0]   r_rd_data;

    logic         r_out_valid;
    logic [7:0]   r_out_byte;
    logic         r_out_dest;
    logic         r_out_last;

    logic         mem_we;
    logic [AW-1:0] mem_waddr;
    logic         out_load;
    logic [7:0]   res_byte;
    logic         res_dest;
    logic         res_last;
    logic [PW-1:0] rd_idx;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_dest  = r_out_dest;
    assign o_run_last  = r_out_last;

    assign mem_waddr = r_count[AW-1:0];
    assign rd_idx    = n_pos - PW'(2);

    // current result word
    always_comb begin
        res_byte = r_echo;
        res_dest = DEST_TERM;
        case (r_mode)
            M_BS: begin
                res_byte = (r_pos == PW'(1)) ? CH_SPACE : CH_BS;
            end
            M_ENTER: begin
                if (r_pos == PW'(0)) begin
                    res_byte = CH_CR;
                end else if (r_pos == PW'(1)) begin
                    res_byte = CH_LF;
                end else if (r_msg_mode) begin
                    res_byte = msg_char(5'(r_pos - PW'(2)));
                end else begin
                    res_byte = r_rd_data;
                    res_dest = DEST_CMD;
                end
            end
            default: res_byte = r_echo;
        endcase
        res_last = (r_pos == r_total - PW'(1));
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_prev_cr  = r_prev_cr;
        n_msg_mode = r_msg_mode;
        n_pos      = r_pos;
        n_total    = r_total;
        n_echo     = r_echo;
        mem_we     = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_pos = '0;
                    if (i_rx_byte == CH_LF && r_prev_cr) begin
                        n_prev_cr = 1'b0;
                    end else begin
                        n_prev_cr = (i_rx_byte == CH_CR);
                        if (i_rx_byte == CH_CR || i_rx_byte == CH_LF) begin
                            n_mode     = M_ENTER;
                            n_msg_mode = r_ovf;
                            n_total    = r_ovf ? PW'(MSG_LEN + 2) : PW'(2) + PW'(r_count);
                            n_count    = '0;
                            n_ovf      = 1'b0;
                            n_state    = S_EMIT;
                        end else if (i_rx_byte == CH_BS || i_rx_byte == CH_DEL) begin
                            if (r_count != '0) begin
                                n_count = r_count - CW'(1);
                                n_mode  = M_BS;
                                n_total = PW'(3);
                                n_state = S_EMIT;
                            end
                        end else if (!r_ovf) begin
                            if (r_count >= CW'(DEPTH)) begin
                                n_ovf = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                n_echo  = i_rx_byte;
                                n_mode  = M_ECHO;
                                n_total = PW'(1);
                                n_state = S_EMIT;
                            end
                        end
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_pos    = r_pos + PW'(1);
                    if (res_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_prev_cr <= 1'b0;
            r_pos     <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_prev_cr <= n_prev_cr;
            r_pos     <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_msg_mode <= n_msg_mode;
        r_total    <= n_total;
        r_echo     <= n_echo;
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= i_rx_byte;
        end
        r_rd_data <= mem[rd_idx[AW-1:0]];
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= res_byte;
            r_out_dest <= res_dest;
            r_out_last <= res_last;
        end
    end

endmodule
